// File: hdl/arht_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// arht_pkg
// shared types and constants of the allocation record hash table
// ---------------------------------------------------------------------------
package arht_pkg;

    // request modes
    localparam logic [1:0] MODE_ALLOC   = 2'd0;
    localparam logic [1:0] MODE_REALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_USAGE  = 2'd0;
    localparam logic [1:0] CFG_MAX_ENTRIES = 2'd1;

    localparam logic [15:0] BASE_USAGE_RST  = 16'd48;
    localparam logic [10:0] MAX_ENTRIES_RST = 11'd512;
    localparam logic [47:0] USAGE_MAX       = 48'hFFFF_FFFF_FFFF;

    // hash constants
    localparam logic [31:0] HASH_MASK = 32'h3fff_ffff;
    localparam int unsigned HSH_A = 18;
    localparam int unsigned HSH_B = 31;
    localparam int unsigned HSH_C = 11;
    localparam int unsigned HSH_D = 6;
    localparam int unsigned HSH_E = 22;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] address;
        logic [31:0] size;
        logic [63:0] new_address;
        logic [31:0] new_size;
        logic [15:0] source_tag;
        logic [31:0] line_number;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] usage;
        logic [47:0] peak_usage;
        logic [10:0] live_count;
        logic [9:0]  slot_index;
        logic [31:0] recorded_size;
        logic [15:0] recorded_source;
        logic [31:0] recorded_line;
    } rsp_t;

endpackage
`default_nettype wire

// File: hdl/arht_hash.sv
`default_nettype none
// ---------------------------------------------------------------------------
// arht_hash
// three-stage pipelined 64-to-32 integer hash, masked to a slot index
// ---------------------------------------------------------------------------
module arht_hash import arht_pkg::*; #(
    parameter int IW = 10
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [63:0]   key,
    output logic      [IW-1:0] home
);

    logic [63:0]   s1_reg, s1_next;
    logic [63:0]   s2_reg, s2_next;
    logic [IW-1:0] home_reg, home_next;
    logic [63:0]   a, c, e;
    logic [31:0]   masked;

    always_comb begin
        a       = (~key) + (key << HSH_A);
        s1_next = a ^ (a >> HSH_B);
        // times 21 as shifted adds
        c       = s1_reg + (s1_reg << 2) + (s1_reg << 4);
        s2_next = c ^ (c >> HSH_C);
        e       = s2_reg + (s2_reg << HSH_D);
        masked  = (e[31:0] ^ e[53:22]) & HASH_MASK;
        home_next = masked[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            home_reg <= home_next;
        end
    end

    assign home = home_reg;

endmodule
`default_nettype wire

// File: hdl/arht_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// arht_front
// accepts requests and computes the home slots of both addresses
// ---------------------------------------------------------------------------
module arht_front import arht_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          hold,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire req_t          s_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output req_t               out_req,
    output logic      [IW-1:0] out_home_a,
    output logic      [IW-1:0] out_home_n
);

    logic [2:0] v_reg, v_next;
    req_t       r0_reg, r1_reg, r2_reg;
    logic       adv;

    assign adv     = !v_reg[2] || out_ready;
    assign s_ready = adv && !hold;

    always_comb begin
        v_next = v_reg;
        if (adv) begin
            v_next = {v_reg[1:0], s_valid && s_ready};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r0_reg <= s_data;
            r1_reg <= r0_reg;
            r2_reg <= r1_reg;
        end
    end

    arht_hash #(.IW(IW)) u_hash_a (
        .aclk (aclk),
        .en   (adv),
        .key  (s_data.address),
        .home (out_home_a)
    );

    arht_hash #(.IW(IW)) u_hash_n (
        .aclk (aclk),
        .en   (adv),
        .key  (s_data.new_address),
        .home (out_home_n)
    );

    assign out_valid = v_reg[2];
    assign out_req   = r2_reg;

endmodule
`default_nettype wire

// File: hdl/arht_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// arht_queue
// four-entry queue between the hashing front and the table back end
// ---------------------------------------------------------------------------
module arht_queue #(
    parameter int W = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output logic      [W-1:0] pop_data
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    logic [W-1:0]  buf_reg [QD];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   fill_reg, fill_next;
    logic          do_push, do_pop;

    assign push_ready = fill_reg != (PW+1)'(QD);
    assign pop_valid  = fill_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = buf_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: hdl/arht_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// arht_back
// slot memory, probe and backward-shift sequencer, usage counters
// ---------------------------------------------------------------------------
module arht_back import arht_pkg::*; #(
    parameter int TABLE_DEPTH = 1024,
    localparam int IW = $clog2(TABLE_DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    output logic               q_ready,
    input  wire req_t          q_req,
    input  wire logic [IW-1:0] q_home_a,
    input  wire logic [IW-1:0] q_home_n,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output logic               clearing,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rsp_t               m_data
);

    localparam int CW = (IW + 1 > 11) ? IW + 1 : 11;
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    typedef struct packed {
        logic          valid;
        logic [IW-1:0] home;
        logic [63:0]   key;
        logic [31:0]   size;
        logic [15:0]   src;
        logic [31:0]   line;
    } word_t;

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b000_0000_0001,
        S_IDLE    = 11'b000_0000_0010,
        S_FIND_A  = 11'b000_0000_0100,
        S_FIND_N  = 11'b000_0000_1000,
        S_REMOVE  = 11'b000_0001_0000,
        S_REM_END = 11'b000_0010_0000,
        S_REHOME  = 11'b000_0100_0000,
        S_ADD     = 11'b000_1000_0000,
        S_SUB     = 11'b001_0000_0000,
        S_PEAK    = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } state_t;

    word_t mem [TABLE_DEPTH];
    word_t rd_word_reg;

    state_t        state_reg, state_next;
    req_t          op_reg, op_next;
    logic [IW-1:0] home_a_reg, home_a_next;
    logic [IW-1:0] home_n_reg, home_n_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] n_reg, n_next;
    logic [IW-1:0] hole_reg, hole_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] fslot_reg, fslot_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic          post_reg, post_next;
    logic [2:0]    status_reg, status_next;
    logic [31:0]   rsize_reg, rsize_next;
    logic [15:0]   rsrc_reg, rsrc_next;
    logic [31:0]   rline_reg, rline_next;
    logic [31:0]   add_reg, add_next;
    logic [31:0]   sub_reg, sub_next;
    logic          peak_en_reg, peak_en_next;
    logic [48:0]   sum_reg, sum_next;
    logic [47:0]   usage_reg, usage_next;
    logic [47:0]   peak_reg, peak_next;
    logic [10:0]   count_reg, count_next;
    logic [15:0]   base_reg, base_next;
    logic [10:0]   max_reg, max_next;
    logic          out_valid_reg, out_valid_next;
    rsp_t          out_reg, out_next;

    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    word_t         wr_data;
    logic [63:0]   key_cur;
    logic          hit, empty, last, movable;
    logic [IW-1:0] idx_inc, fslot_inc;
    logic [CW-1:0] limit;
    logic          full_alloc, full_realloc;
    logic [48:0]   diff;

    always_comb begin
        key_cur   = (state_reg == S_FIND_A) ? op_reg.address : op_reg.new_address;
        hit       = rd_word_reg.valid && (rd_word_reg.key == key_cur);
        empty     = !rd_word_reg.valid;
        last      = n_reg == LAST;
        idx_inc   = idx_reg + IW'(1);
        fslot_inc = fslot_reg + IW'(1);
        limit     = (CW'(max_reg) < CW'(TABLE_DEPTH)) ? CW'(max_reg) : CW'(TABLE_DEPTH);
        full_alloc   = CW'(count_reg) >= limit;
        full_realloc = CW'(count_reg - 11'd1) >= limit;
        // may the entry at j fill the hole, given its home slot
        if (j_reg > hole_reg) begin
            movable = (rd_word_reg.home <= hole_reg) || (rd_word_reg.home > j_reg);
        end else begin
            movable = (rd_word_reg.home <= hole_reg) && (rd_word_reg.home > j_reg);
        end
        diff = (sum_reg >= 49'(sub_reg)) ? sum_reg - 49'(sub_reg) : '0;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        home_a_next  = home_a_reg;
        home_n_next  = home_n_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        hole_next    = hole_reg;
        j_next       = j_reg;
        fslot_next   = fslot_reg;
        slot_next    = slot_reg;
        clr_idx_next = clr_idx_reg;
        post_next    = post_reg;
        status_next  = status_reg;
        rsize_next   = rsize_reg;
        rsrc_next    = rsrc_reg;
        rline_next   = rline_reg;
        add_next     = add_reg;
        sub_next     = sub_reg;
        peak_en_next = peak_en_reg;
        sum_next     = sum_reg;
        usage_next   = usage_reg;
        peak_next    = peak_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        max_next     = max_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next     = out_reg;
        q_ready      = 1'b0;
        rd_addr      = idx_inc;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + IW'(1);
                if (clr_idx_reg == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                rd_addr = q_home_a;
                if (q_valid) begin
                    q_ready     = 1'b1;
                    op_next     = q_req;
                    home_a_next = q_home_a;
                    home_n_next = q_home_n;
                    idx_next    = q_home_a;
                    n_next      = '0;
                    post_next   = 1'b0;
                    status_next = ST_OK;
                    slot_next   = '0;
                    rsize_next  = '0;
                    rsrc_next   = '0;
                    rline_next  = '0;
                    state_next  = (q_req.mode == MODE_NONE) ? S_OUT : S_FIND_A;
                end
            end
            S_FIND_A: begin
                idx_next = idx_inc;
                n_next   = n_reg + IW'(1);
                if (hit) begin
                    slot_next  = idx_reg;
                    fslot_next = idx_reg;
                    rsize_next = rd_word_reg.size;
                    rsrc_next  = rd_word_reg.src;
                    rline_next = rd_word_reg.line;
                    if (op_reg.mode == MODE_ALLOC) begin
                        status_next = ST_DUP;
                        state_next  = S_OUT;
                    end else if (rd_word_reg.size != op_reg.size) begin
                        status_next = ST_MISMATCH;
                        state_next  = S_OUT;
                    end else if (op_reg.mode == MODE_FREE) begin
                        hole_next    = idx_reg;
                        j_next       = idx_inc;
                        n_next       = '0;
                        add_next     = '0;
                        sub_next     = op_reg.size;
                        peak_en_next = 1'b0;
                        state_next   = S_REMOVE;
                    end else if (op_reg.new_address != op_reg.address) begin
                        rd_addr    = home_n_reg;
                        idx_next   = home_n_reg;
                        n_next     = '0;
                        state_next = S_FIND_N;
                    end else if (full_realloc) begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end else begin
                        hole_next    = idx_reg;
                        j_next       = idx_inc;
                        n_next       = '0;
                        add_next     = op_reg.new_size;
                        sub_next     = op_reg.size;
                        peak_en_next = 1'b1;
                        state_next   = S_REMOVE;
                    end
                end else if (empty || last) begin
                    if (op_reg.mode != MODE_ALLOC) begin
                        status_next = ST_UNKNOWN;
                        state_next  = S_OUT;
                    end else if (full_alloc || !empty) begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = '{valid: 1'b1, home: home_a_reg, key: op_reg.address,
                                    size: op_reg.size, src: op_reg.source_tag,
                                    line: op_reg.line_number};
                        count_next   = count_reg + 11'd1;
                        slot_next    = idx_reg;
                        rsize_next   = op_reg.size;
                        rsrc_next    = op_reg.source_tag;
                        rline_next   = op_reg.line_number;
                        add_next     = op_reg.size;
                        sub_next     = '0;
                        peak_en_next = 1'b1;
                        state_next   = S_ADD;
                    end
                end
            end
            S_FIND_N: begin
                idx_next = idx_inc;
                n_next   = n_reg + IW'(1);
                if (!post_reg) begin
                    // new address must not be held by another record
                    if (hit) begin
                        status_next = ST_DUP;
                        slot_next   = idx_reg;
                        rsize_next  = rd_word_reg.size;
                        rsrc_next   = rd_word_reg.src;
                        rline_next  = rd_word_reg.line;
                        state_next  = S_OUT;
                    end else if (empty || last) begin
                        if (full_realloc) begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end else begin
                            rd_addr      = fslot_inc;
                            hole_next    = fslot_reg;
                            j_next       = fslot_inc;
                            n_next       = '0;
                            add_next     = op_reg.new_size;
                            sub_next     = op_reg.size;
                            peak_en_next = 1'b1;
                            state_next   = S_REMOVE;
                        end
                    end
                end else begin
                    if (empty) begin
                        wr_en   = 1'b1;
                        wr_addr = idx_reg;
                        wr_data = '{valid: 1'b1, home: home_n_reg, key: op_reg.new_address,
                                    size: op_reg.new_size, src: op_reg.source_tag,
                                    line: op_reg.line_number};
                        count_next = count_reg + 11'd1;
                        slot_next  = idx_reg;
                        state_next = S_ADD;
                    end else if (hit || last) begin
                        state_next = S_ADD;
                    end
                end
            end
            S_REMOVE: begin
                rd_addr = j_reg + IW'(1);
                j_next  = j_reg + IW'(1);
                n_next  = n_reg + IW'(1);
                if (empty) begin
                    state_next = S_REM_END;
                end else begin
                    if (movable) begin
                        wr_en     = 1'b1;
                        wr_addr   = hole_reg;
                        wr_data   = rd_word_reg;
                        hole_next = j_reg;
                    end
                    if (last) begin
                        state_next = S_REM_END;
                    end
                end
            end
            S_REM_END: begin
                wr_en      = 1'b1;
                wr_addr    = hole_reg;
                count_next = count_reg - 11'd1;
                state_next = (op_reg.mode == MODE_REALLOC) ? S_REHOME : S_ADD;
            end
            S_REHOME: begin
                rd_addr    = home_n_reg;
                idx_next   = home_n_reg;
                n_next     = '0;
                post_next  = 1'b1;
                state_next = S_FIND_N;
            end
            S_ADD: begin
                sum_next   = {1'b0, usage_reg} + 49'(add_reg);
                state_next = S_SUB;
            end
            S_SUB: begin
                usage_next = diff[48] ? USAGE_MAX : diff[47:0];
                state_next = S_PEAK;
            end
            S_PEAK: begin
                if (peak_en_reg && (usage_reg > peak_reg)) begin
                    peak_next = usage_reg;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_next = '{status: status_reg, usage: usage_reg,
                                 peak_usage: peak_reg, live_count: count_reg,
                                 slot_index: 10'(slot_reg), recorded_size: rsize_reg,
                                 recorded_source: rsrc_reg, recorded_line: rline_reg};
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we) begin
            if (cfg_index == CFG_BASE_USAGE) begin
                base_next  = cfg_data;
                usage_next = 48'(cfg_data);
            end else if (cfg_index == CFG_MAX_ENTRIES) begin
                max_next = cfg_data[10:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            usage_reg     <= 48'(BASE_USAGE_RST);
            peak_reg      <= '0;
            count_reg     <= '0;
            base_reg      <= BASE_USAGE_RST;
            max_reg       <= MAX_ENTRIES_RST;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            usage_reg     <= usage_next;
            peak_reg      <= peak_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        home_a_reg  <= home_a_next;
        home_n_reg  <= home_n_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        hole_reg    <= hole_next;
        j_reg       <= j_next;
        fslot_reg   <= fslot_next;
        slot_reg    <= slot_next;
        post_reg    <= post_next;
        status_reg  <= status_next;
        rsize_reg   <= rsize_next;
        rsrc_reg    <= rsrc_next;
        rline_reg   <= rline_next;
        add_reg     <= add_next;
        sub_reg     <= sub_next;
        peak_en_reg <= peak_en_next;
        sum_reg     <= sum_next;
        out_reg     <= out_next;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= mem[rd_addr];
    end

    assign clearing = state_reg == S_CLEAR;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(count_reg) <= CW'(TABLE_DEPTH))
        else $error("record count exceeds table depth");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("slot memory written while idle");

    a_clear_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !q_ready)
        else $error("item taken during clearing pass");

    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REM_END) |=> (count_reg == $past(count_reg) - 11'd1))
        else $error("removal did not lower the record count");

endmodule
`default_nettype wire

// File: hdl/allocation_record_hash_table_core.sv
`default_nettype none
// path: three hash stages, the queue, the idle state that starts the first slot read, then
//   a probe step for each probed slot, a step for each slot walked by the backward shift and
//   one to close the hole on free or reallocate, a rehome step and a second probe on
//   reallocate, and the add, subtract, peak and output states (output state alone on an error)
// the back end takes one request at a time and takes the next only on its return to idle
// reset: a clearing pass over all TABLE_DEPTH slots empties the table, s_ready low
// ---------------------------------------------------------------------------
// allocation_record_hash_table_core
// open-addressing allocation tracker with usage and peak counters
// ---------------------------------------------------------------------------
module allocation_record_hash_table_core import arht_pkg::*; #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire req_t        s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output rsp_t             m_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int QW = $bits(req_t) + 2 * IW;

    logic          clearing;
    logic          f_valid, f_ready;
    req_t          f_req;
    logic [IW-1:0] f_home_a, f_home_n;
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    req_t          q_req;
    logic [IW-1:0] q_home_a, q_home_n;

    assign cfg_ready = 1'b1;

    arht_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hold       (clearing),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_req    (f_req),
        .out_home_a (f_home_a),
        .out_home_n (f_home_n)
    );

    arht_queue #(.W(QW)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_req, f_home_a, f_home_n}),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign q_req    = q_data[QW-1:2*IW];
    assign q_home_a = q_data[2*IW-1:IW];
    assign q_home_n = q_data[IW-1:0];

    arht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_req     (q_req),
        .q_home_a  (q_home_a),
        .q_home_n  (q_home_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// allocation record table check: directed and random allocate, reallocate
// and free traffic against a behavioral table, with random idling on both
// channels and several register settings
// ---------------------------------------------------------------------------
module tb_top;
    import arht_pkg::*;

    localparam int DEPTH = 1024;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    req_t        s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    rsp_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    allocation_record_hash_table_core #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // behavioral table state
    logic        tbl_valid [DEPTH];
    logic [63:0] tbl_key   [DEPTH];
    logic [31:0] tbl_size  [DEPTH];
    logic [15:0] tbl_src   [DEPTH];
    logic [31:0] tbl_line  [DEPTH];
    logic [47:0] usage_now;
    logic [47:0] usage_high;
    logic [10:0] live_now;
    logic [15:0] base_reg;
    logic [10:0] limit_reg;

    rsp_t        expected_rsp [$];
    logic [63:0] live_keys [$];
    logic [31:0] live_sizes [$];
    int          errors = 0;
    int unsigned cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic logic [9:0] home_of(logic [63:0] key);
        logic [63:0] k;
        k = (~key) + (key << 18);
        k = k ^ (k >> 31);
        k = k * 64'd21;
        k = k ^ (k >> 11);
        k = k + (k << 6);
        k = k ^ (k >> 22);
        return k[9:0];
    endfunction

    // returns found flag; hole gets first empty slot, has_hole whether seen
    function automatic logic lookup(logic [63:0] key, output logic [9:0] at,
                                    output logic [9:0] hole, output logic has_hole);
        logic [9:0] i;
        i = home_of(key);
        at = '0; hole = '0; has_hole = 1'b0;
        for (int n = 0; n < DEPTH; n++) begin
            if (!tbl_valid[i]) begin
                hole = i; has_hole = 1'b1;
                return 1'b0;
            end
            if (tbl_key[i] == key) begin
                at = i;
                return 1'b1;
            end
            i = i + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void drop_slot(logic [9:0] hole_in);
        logic [9:0] hole, j, h;
        logic movable;
        hole = hole_in;
        j = hole;
        for (int n = 0; n < DEPTH; n++) begin
            j = j + 1'b1;
            if (!tbl_valid[j]) break;
            h = home_of(tbl_key[j]);
            if (j > hole) movable = (h <= hole) || (h > j);
            else movable = (h <= hole) && (h > j);
            if (movable) begin
                tbl_key[hole] = tbl_key[j];
                tbl_size[hole] = tbl_size[j];
                tbl_src[hole] = tbl_src[j];
                tbl_line[hole] = tbl_line[j];
                hole = j;
            end
        end
        tbl_valid[hole] = 1'b0;
        live_now = live_now - 1'b1;
    endfunction

    function automatic void store_slot(logic [9:0] i, req_t r, logic [63:0] key,
                                       logic [31:0] sz);
        tbl_valid[i] = 1'b1;
        tbl_key[i] = key;
        tbl_size[i] = sz;
        tbl_src[i] = r.source_tag;
        tbl_line[i] = r.line_number;
        live_now = live_now + 1'b1;
    endfunction

    function automatic void track_drop(logic [63:0] key);
        foreach (live_keys[i])
            if (live_keys[i] == key) begin
                live_keys.delete(i);
                live_sizes.delete(i);
                return;
            end
    endfunction

    function automatic rsp_t predict_request(req_t r);
        rsp_t o;
        logic [9:0] at, hole, other, h2;
        logic found, has_hole, dup, hh2;
        int unsigned lim;
        logic [49:0] t;
        o = '0;
        lim = (limit_reg < DEPTH) ? limit_reg : DEPTH;
        if (r.mode == MODE_ALLOC) begin
            found = lookup(r.address, at, hole, has_hole);
            if (found) begin
                o.status = ST_DUP; o.slot_index = at;
                o.recorded_size = tbl_size[at]; o.recorded_source = tbl_src[at];
                o.recorded_line = tbl_line[at];
            end else if (live_now >= lim || !has_hole) begin
                o.status = ST_FULL;
            end else begin
                store_slot(hole, r, r.address, r.size);
                live_keys.push_back(r.address); live_sizes.push_back(r.size);
                o.status = ST_OK; o.slot_index = hole;
                o.recorded_size = r.size; o.recorded_source = r.source_tag;
                o.recorded_line = r.line_number;
                t = {2'b0, usage_now} + r.size;
                usage_now = (t > USAGE_MAX) ? USAGE_MAX : t[47:0];
                if (usage_now > usage_high) usage_high = usage_now;
            end
        end else if (r.mode == MODE_REALLOC || r.mode == MODE_FREE) begin
            found = lookup(r.address, at, hole, has_hole);
            if (!found) begin
                o.status = ST_UNKNOWN;
            end else begin
                o.slot_index = at;
                o.recorded_size = tbl_size[at]; o.recorded_source = tbl_src[at];
                o.recorded_line = tbl_line[at];
                if (tbl_size[at] != r.size) begin
                    o.status = ST_MISMATCH;
                end else if (r.mode == MODE_FREE) begin
                    drop_slot(at);
                    track_drop(r.address);
                    usage_now = (usage_now >= r.size) ? usage_now - r.size : '0;
                end else begin
                    dup = 1'b0;
                    if (r.new_address != r.address)
                        dup = lookup(r.new_address, other, h2, hh2);
                    if (dup) begin
                        o.status = ST_DUP; o.slot_index = other;
                        o.recorded_size = tbl_size[other];
                        o.recorded_source = tbl_src[other];
                        o.recorded_line = tbl_line[other];
                    end else if (int'(live_now) - 1 >= int'(lim)) begin
                        o.status = ST_FULL;
                    end else begin
                        drop_slot(at);
                        track_drop(r.address);
                        void'(lookup(r.new_address, other, h2, hh2));
                        if (hh2) begin
                            store_slot(h2, r, r.new_address, r.new_size);
                            live_keys.push_back(r.new_address);
                            live_sizes.push_back(r.new_size);
                            o.slot_index = h2;
                        end
                        t = {2'b0, usage_now} + r.new_size;
                        t = (t >= r.size) ? t - r.size : '0;
                        usage_now = (t > USAGE_MAX) ? USAGE_MAX : t[47:0];
                        if (usage_now > usage_high) usage_high = usage_now;
                    end
                end
            end
        end
        o.usage = usage_now;
        o.peak_usage = usage_high;
        o.live_count = live_now;
        return o;
    endfunction

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result checker with random stall
    always @(posedge aclk) begin
        rsp_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, m_data);
            end else begin
                exp_r = expected_rsp.pop_front();
                if (m_data.status !== exp_r.status || m_data.usage !== exp_r.usage ||
                    m_data.peak_usage !== exp_r.peak_usage ||
                    m_data.live_count !== exp_r.live_count ||
                    m_data.slot_index !== exp_r.slot_index ||
                    m_data.recorded_size !== exp_r.recorded_size ||
                    m_data.recorded_source !== exp_r.recorded_source ||
                    m_data.recorded_line !== exp_r.recorded_line) begin
                    errors++;
                    $display("%0t: mismatch expected %h actual %h", $time, exp_r, m_data);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high between back-to-back items; idle cycles and drain drop it
    task automatic send_request(req_t r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_rsp.push_back(predict_request(r));
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_BASE_USAGE) begin
            base_reg = val;
            usage_now = {32'b0, val};
        end else begin
            limit_reg = val[10:0];
        end
    endtask

    function automatic req_t make_req(logic [1:0] m, logic [63:0] a, logic [31:0] sz);
        req_t r;
        r.mode = m; r.address = a; r.size = sz;
        r.new_address = {$urandom, $urandom}; r.new_size = $urandom;
        r.source_tag = $urandom; r.line_number = $urandom;
        return r;
    endfunction

    task automatic test_directed;
        req_t r;
        send_request(make_req(MODE_FREE, 64'h0, 32'h0));        // unknown on empty
        send_request(make_req(MODE_ALLOC, 64'h0, 32'hFFFF_FFFF));
        send_request(make_req(MODE_ALLOC, 64'h0, 32'h1));        // duplicate
        send_request(make_req(MODE_ALLOC, '1, 32'h0));
        send_request(make_req(MODE_FREE, 64'h0, 32'h5));         // size mismatch
        r = make_req(MODE_REALLOC, 64'h0, 32'hFFFF_FFFF);
        r.new_address = '1;                                      // duplicate target
        send_request(r);
        r.new_address = 64'h0; r.new_size = 32'h10;              // same address
        send_request(r);
        r = make_req(MODE_REALLOC, 64'h0, 32'h10);
        r.new_address = 64'h1234_5678_9ABC_DEF0; r.new_size = 32'hFFFF_FFFF;
        send_request(r);
        send_request(make_req(MODE_REALLOC, 64'h55, 32'h1));     // unknown
        send_request(make_req(MODE_NONE, 64'h1234_5678_9ABC_DEF0, 32'h0));
        send_request(make_req(MODE_FREE, 64'h1234_5678_9ABC_DEF0, 32'hFFFF_FFFF));
        send_request(make_req(MODE_FREE, '1, 32'h0));
        // colliding keys to exercise probe chains and backward shift
        for (int i = 0; i < 8; i++)
            send_request(make_req(MODE_ALLOC, 64'(i * 1024), 32'(i)));
        for (int i = 0; i < 8; i += 2)
            send_request(make_req(MODE_FREE, 64'(i * 1024), 32'(i)));
        for (int i = 1; i < 8; i += 2)
            send_request(make_req(MODE_FREE, 64'(i * 1024), 32'(i)));
    endtask

    task automatic test_limits;
        req_t r;
        write_reg(CFG_MAX_ENTRIES, 16'd1);
        send_request(make_req(MODE_ALLOC, 64'hA, 32'd3));
        send_request(make_req(MODE_ALLOC, 64'hB, 32'd3));        // full
        r = make_req(MODE_REALLOC, 64'hA, 32'd3);
        send_request(r);
        write_reg(CFG_BASE_USAGE, 16'hFFFF);
        write_reg(CFG_MAX_ENTRIES, 16'd0);                       // lowered: realloc full
        send_request(make_req(MODE_REALLOC, r.new_address, r.new_size));
        send_request(make_req(MODE_FREE, r.new_address, r.new_size));
        write_reg(CFG_BASE_USAGE, 16'd0);
        write_reg(CFG_MAX_ENTRIES, 16'd2047);
        send_request(make_req(MODE_FREE, r.new_address, r.new_size));
        send_request(make_req(MODE_FREE, 64'hA, 32'd3));         // unknown, moved by the reallocate
    endtask

    // mostly well-formed traffic on live records, some noise
    task automatic test_random(int count, int max_live);
        req_t r;
        int k, sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            r = make_req(MODE_ALLOC, {$urandom, $urandom}, $urandom);
            if ($urandom_range(3) == 0) r.size = $urandom_range(255);
            if (live_keys.size() > 0 && (sel < 45 || live_keys.size() >= max_live)) begin
                k = $urandom_range(live_keys.size() - 1);
                r.address = live_keys[k];
                r.size = live_sizes[k];
                r.mode = ($urandom_range(1)) ? MODE_FREE : MODE_REALLOC;
                if (sel < 4) r.size = r.size ^ 32'h1;
                if (sel < 8 && live_keys.size() > 1)
                    r.new_address = live_keys[$urandom_range(live_keys.size() - 1)];
                if (sel >= 90) r.mode = MODE_ALLOC;              // duplicate
            end else if (sel >= 95) begin
                r.mode = 2'($urandom_range(3));
            end
            send_request(r);
        end
    endtask

    initial begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        base_reg = BASE_USAGE_RST;
        limit_reg = MAX_ENTRIES_RST;
        usage_now = {32'b0, BASE_USAGE_RST};
        usage_high = '0;
        live_now = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_limits();
        test_random(350, 200);
        drain();
        send_idle_pct = 59;
        test_random(300, 40);
        drain();
        send_idle_pct = 0; recv_stall_pct = 59;
        write_reg(CFG_MAX_ENTRIES, 16'd1024);
        write_reg(CFG_BASE_USAGE, 16'd1000);
        test_random(350, 1100);
        drain();
        send_idle_pct = 8; recv_stall_pct = 8;
        write_reg(CFG_MAX_ENTRIES, 16'd20);
        test_random(250, 30);
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
